// ===== design/ep_pkg.sv =====
package ep_pkg;

  // configuration register index
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_X = 2'd2,
    REG_RADIUS_Y = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INIT_STEP,
    S_INIT_DEC,
    S_R1_MOVE,
    S_R2_MOVE,
    S_DIFF,
    S_ADD_SQ,
    S_UPDATE,
    S_E_TX,
    S_E_MUL_RY2,
    S_E_TY,
    S_E_MUL_RX2,
    S_E_RXRY,
    S_E_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_INIT_STEP,
    OP_INIT_DEC,
    OP_R1_MOVE,
    OP_R2_MOVE,
    OP_DIFF,
    OP_ADD_SQ,
    OP_UPDATE,
    OP_E_TX,
    OP_E_MUL_RY2,
    OP_E_TY,
    OP_E_MUL_RX2,
    OP_E_RXRY,
    OP_E_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
    logic restart;
  } ep_cmd_t;

  typedef struct packed {
    logic finished;
    logic quad_last;
    logic in_region_two;
    logic cmp_lt;
  } ep_status_t;

endpackage

// ===== design/ep_channels.sv =====
interface ep_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ep_point_if #(
  parameter int OUT_W = 13
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic                    point_valid;
  logic                    done_res;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output done_res, input ready);
  modport sink (input valid, input point_x, input point_y, input point_valid,
                input done_res, output ready);
endinterface

interface ep_cfg_if import ep_pkg::*; #(
  parameter int DATA_W = 12
);
  logic              valid;
  logic              ready;
  cfg_reg_t          index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ep_ctrl.sv =====
module ep_ctrl import ep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_restart,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  ep_status_t status,
  output ep_cmd_t    cmd
);

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.accept  = accept;
    cmd.restart = in_restart;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (in_restart) begin
            state_next = S_INIT;
          end else if (!status.finished && status.quad_last) begin
            state_next = status.in_region_two ? S_R2_MOVE : S_R1_MOVE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_INIT_STEP;
      end
      S_INIT_STEP: begin
        cmd.op     = OP_INIT_STEP;
        state_next = S_INIT_DEC;
      end
      S_INIT_DEC: begin
        // step_dy is settled here, step_dx is zero
        cmd.op     = OP_INIT_DEC;
        state_next = status.cmp_lt ? S_IDLE : S_E_TX;
      end
      S_R1_MOVE: begin
        cmd.op     = OP_R1_MOVE;
        state_next = S_DIFF;
      end
      S_R2_MOVE: begin
        cmd.op     = OP_R2_MOVE;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_ADD_SQ;
      end
      S_ADD_SQ: begin
        cmd.op     = OP_ADD_SQ;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.op = OP_UPDATE;
        if (status.in_region_two || status.cmp_lt) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_E_TX;
        end
      end
      S_E_TX: begin
        cmd.op     = OP_E_TX;
        state_next = S_E_MUL_RY2;
      end
      S_E_MUL_RY2: begin
        cmd.op     = OP_E_MUL_RY2;
        state_next = S_E_TY;
      end
      S_E_TY: begin
        cmd.op     = OP_E_TY;
        state_next = S_E_MUL_RX2;
      end
      S_E_MUL_RX2: begin
        cmd.op     = OP_E_MUL_RX2;
        state_next = S_E_RXRY;
      end
      S_E_RXRY: begin
        cmd.op     = OP_E_RXRY;
        state_next = S_E_DONE;
      end
      S_E_DONE: begin
        cmd.op     = OP_E_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ep_datapath.sv =====
module ep_datapath import ep_pkg::*; #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12,
  parameter int CFG_W       = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  cfg_reg_t                     cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  ep_cmd_t                      cmd,
  output ep_status_t                   status,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         point_valid,
  output logic                         done_res
);

  localparam int R      = RADIUS_BITS;
  localparam int OUT_W  = COORD_BITS + 1;
  localparam int PX_W   = R + 1;
  localparam int PY_W   = R + 2;
  localparam int TX_W   = R + 2;
  localparam int TY_W   = R + 3;
  localparam int SQ_W   = 2 * R;
  localparam int STEP_W = 3 * R + 3;
  localparam int TMP_W  = STEP_W + 2;
  localparam int DEC_W  = 4 * R + 8;
  localparam int MA_W   = 2 * R + 5;
  localparam int MB_W   = 2 * R + 1;
  localparam int PROD_W = MA_W + MB_W;

  // configuration registers and their squares
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic [R-1:0]                 radius_x, radius_y;
  logic [SQ_W-1:0]              rx2, ry2;

  // generator state
  logic [PX_W-1:0]          pos_x;
  logic signed [PY_W-1:0]   pos_y;
  logic signed [STEP_W-1:0] step_dx, step_dy;
  logic signed [DEC_W-1:0]  decision;
  logic                     in_region_two;
  logic [1:0]               quadrant;
  logic                     finished;

  // working registers
  logic                     br;
  logic signed [TMP_W-1:0]  tmp;
  logic signed [PROD_W-1:0] prod;

  logic signed [STEP_W-1:0] rx2_x2, ry2_x2, diff_a, diff_b;
  logic signed [TMP_W-1:0]  sq_tmp;
  logic signed [DEC_W-1:0]  rx2_d, ry2_d, prod_d, tmp_d;
  logic [TX_W-1:0]          tx;
  logic signed [TY_W-1:0]   ty;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [OUT_W-1:0]         cx_e, cy_e, px_e, py_e;
  logic                     dec_neg, dec_pos;

  assign rx2_x2 = STEP_W'($signed({1'b0, rx2})) <<< 1;
  assign ry2_x2 = STEP_W'($signed({1'b0, ry2})) <<< 1;
  assign rx2_d  = DEC_W'($signed({1'b0, rx2}));
  assign ry2_d  = DEC_W'($signed({1'b0, ry2}));
  assign prod_d = DEC_W'(prod);
  assign tmp_d  = DEC_W'(tmp);
  assign sq_tmp = in_region_two ? TMP_W'($signed({1'b0, rx2}))
                                : TMP_W'($signed({1'b0, ry2}));
  assign tx     = {pos_x, 1'b1};
  assign ty     = TY_W'(pos_y) - TY_W'(1);

  assign dec_neg = decision[DEC_W-1];
  assign dec_pos = !decision[DEC_W-1] && (|decision);

  // region one drops step_dy when the last move was horizontal,
  // region two drops step_dx when the last move was vertical
  always_comb begin
    if (in_region_two) begin
      diff_a = br ? '0 : step_dx;
      diff_b = step_dy;
    end else begin
      diff_a = step_dx;
      diff_b = br ? '0 : step_dy;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_INIT, OP_INIT_STEP: begin
        mul_a = MA_W'($signed({1'b0, radius_y}));
        mul_b = MB_W'($signed({1'b0, rx2}));
      end
      OP_E_TX: begin
        mul_a = MA_W'($signed({1'b0, tx}));
        mul_b = MB_W'($signed({1'b0, tx}));
      end
      OP_E_MUL_RY2: begin
        mul_a = $signed(prod[MA_W-1:0]);
        mul_b = MB_W'($signed({1'b0, ry2}));
      end
      OP_E_TY: begin
        mul_a = MA_W'(ty);
        mul_b = MB_W'(ty);
      end
      OP_E_MUL_RX2: begin
        mul_a = $signed(prod[MA_W-1:0]);
        mul_b = MB_W'($signed({1'b0, rx2}));
      end
      OP_E_RXRY: begin
        mul_a = MA_W'($signed({1'b0, rx2}));
        mul_b = MB_W'($signed({1'b0, ry2}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // symmetric copy of the current position
  assign cx_e = OUT_W'(center_x);
  assign cy_e = OUT_W'(center_y);
  assign px_e = quadrant[0] ? cx_e - OUT_W'(pos_x) : cx_e + OUT_W'(pos_x);
  assign py_e = quadrant[1] ? cy_e - OUT_W'(pos_y) : cy_e + OUT_W'(pos_y);

  assign status.finished      = finished;
  assign status.quad_last     = (quadrant == 2'd3);
  assign status.in_region_two = in_region_two;
  assign status.cmp_lt        = step_dx < step_dy;

  always_ff @(posedge clk) begin
    rx2 <= SQ_W'(radius_x) * SQ_W'(radius_x);
    ry2 <= SQ_W'(radius_y) * SQ_W'(radius_y);
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius_x <= '0;
      radius_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_CENTER_Y: center_y <= $signed(cfg_data[COORD_BITS-1:0]);
        REG_RADIUS_X: radius_x <= cfg_data[R-1:0];
        REG_RADIUS_Y: radius_y <= cfg_data[R-1:0];
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      priority if (cmd.restart) begin
        point_x     <= '0;
        point_y     <= '0;
        point_valid <= 1'b0;
        done_res    <= 1'b0;
      end else if (finished) begin
        point_x     <= '0;
        point_y     <= '0;
        point_valid <= 1'b0;
        done_res    <= 1'b1;
      end else begin
        point_x     <= $signed(px_e);
        point_y     <= $signed(py_e);
        point_valid <= 1'b1;
        done_res    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      step_dx       <= '0;
      step_dy       <= '0;
      decision      <= '0;
      in_region_two <= 1'b0;
      quadrant      <= '0;
      finished      <= 1'b1;
    end else begin
      if (cmd.accept && !cmd.restart && !finished) begin
        quadrant <= quadrant + 2'd1;
      end
      unique case (cmd.op)
        OP_INIT: begin
          pos_x         <= '0;
          pos_y         <= PY_W'($signed({1'b0, radius_y}));
          step_dx       <= '0;
          in_region_two <= 1'b0;
          quadrant      <= '0;
          finished      <= 1'b0;
        end
        OP_INIT_STEP: begin
          step_dy  <= STEP_W'(prod) <<< 1;
          decision <= (ry2_d <<< 2) + rx2_d;
        end
        OP_INIT_DEC: begin
          decision <= decision - (prod_d <<< 2);
        end
        OP_R1_MOVE: begin
          pos_x   <= pos_x + PX_W'(1);
          step_dx <= step_dx + ry2_x2;
          br      <= dec_neg;
          if (!dec_neg) begin
            pos_y   <= pos_y - PY_W'(1);
            step_dy <= step_dy - rx2_x2;
          end
        end
        OP_R2_MOVE: begin
          pos_y   <= pos_y - PY_W'(1);
          step_dy <= step_dy - rx2_x2;
          br      <= dec_pos;
          if (!dec_pos) begin
            pos_x   <= pos_x + PX_W'(1);
            step_dx <= step_dx + ry2_x2;
          end
        end
        OP_DIFF: begin
          tmp <= TMP_W'(diff_a) - TMP_W'(diff_b);
        end
        OP_ADD_SQ: begin
          tmp <= tmp + sq_tmp;
        end
        OP_UPDATE: begin
          decision <= decision + (tmp_d <<< 2);
          if (in_region_two && pos_y[PY_W-1]) begin
            finished <= 1'b1;
          end
        end
        OP_E_TY: begin
          decision <= prod_d;
        end
        OP_E_RXRY: begin
          decision <= decision + (prod_d <<< 2);
        end
        OP_E_DONE: begin
          decision      <= decision - (prod_d <<< 2);
          in_region_two <= 1'b1;
          if (pos_y[PY_W-1]) begin
            finished <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ellipse_point_generator.sv =====
// midpoint ellipse point generator
// tick: one word per request; restart=1 reloads the run from the config
//   registers and returns an empty word, restart=0 returns the next point
// point: one word per tick; each position is sent as four mirrored copies
//   (+x+y, -x+y, +x-y, -x-y), then done_res=1 with point_valid=0 once the
//   run is over; point_valid=0, done_res=0 on a restart
// cfg: register writes (center_x, center_y, radius_x, radius_y), always
//   ready, to be used only while the block is idle
// output: the result word is registered and shows in the cycle after accept
// throughput: one tick per cycle for the first three copies while the point
//   channel is ready; after the fourth copy the generator runs its move, diff,
//   add-square and update states, plus the region-two states when it crosses
//   into region two (the chained multiplies of its decision go through one shared registered multiplier);
//   a restart runs the init states, plus the region-two states if it starts there
// reset: no run in progress, ticks return done_res=1, the config registers clear to 0
// a stalled point channel holds the pending word; one new tick is taken
//   in the same cycle the pending word leaves
module ellipse_point_generator import ep_pkg::*; #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic         clk,
  input  logic         rst,
  ep_tick_if.sink      tick,
  ep_point_if.source   point,
  ep_cfg_if.sink       cfg
);

  localparam int CFG_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  ep_cmd_t    cmd;
  ep_status_t status;
  logic       cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  ep_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tick.valid),
    .in_restart (tick.restart),
    .in_ready   (tick.ready),
    .out_ready  (point.ready),
    .out_valid  (point.valid),
    .status     (status),
    .cmd        (cmd)
  );

  ep_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .CFG_W       (CFG_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg.index),
    .cfg_data    (CFG_W'(cfg.data)),
    .cmd         (cmd),
    .status      (status),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_valid (point.point_valid),
    .done_res    (point.done_res)
  );

endmodule
